// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the segment offset translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SOT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sot assertion failed");
`define SOT_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("sot forbidden condition seen");
`else
`define SOT_ASSERT(lbl, clk, rst, prop)
`define SOT_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- rtl/sot_pkg.sv -----
// Types and constants shared by the segment offset translator.
`timescale 1ns / 1ps
package sot_pkg;

  localparam int SOT_MAX_SEGMENTS = 64;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_PATCH  = 2'd2;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_WRITE    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] length;
  } seg_entry_t;

  typedef enum logic {
    ALU_SUB,
    ALU_ADD
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] result;
    logic        borrow;
  } alu_rsp_t;

endpackage

// ----- rtl/sot_if.sv -----
// Request and response channel interfaces of the segment offset translator.
`timescale 1ns / 1ps
interface sot_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] seg_base_in;
  logic [31:0] seg_length_in;
  logic [31:0] flat_offset;
  logic [7:0]  patch_byte;

  modport source (
    output valid, opcode, seg_base_in, seg_length_in, flat_offset, patch_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, seg_base_in, seg_length_in, flat_offset, patch_byte,
    output ready
  );
endinterface

interface sot_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] write_address;
  logic [7:0]  write_byte;

  modport source (
    output valid, status, write_address, write_byte,
    input  ready
  );
  modport sink (
    input  valid, status, write_address, write_byte,
    output ready
  );
endinterface

// ----- rtl/sot_alu.sv -----
// Shared subtract and add unit used by the segment walk.
`timescale 1ns / 1ps
module sot_alu (
  input  sot_pkg::alu_req_t req,
  output sot_pkg::alu_rsp_t rsp
);
  import sot_pkg::*;

  logic [32:0] diff;

  assign diff = {1'b0, req.a} - {1'b0, req.b};

  always_comb begin
    case (req.op)
      ALU_ADD: begin
        rsp.result = req.a + req.b;
        rsp.borrow = 1'b0;
      end
      default: begin
        rsp.result = diff[31:0];
        rsp.borrow = diff[32];
      end
    endcase
  end

endmodule

// ----- rtl/sot_table.sv -----
// Segment table memory with one write port and one registered read port.
`timescale 1ns / 1ps
module sot_table #(
  parameter int DEPTH = sot_pkg::SOT_MAX_SEGMENTS,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  sot_pkg::seg_entry_t wr_data,
  input  logic [IDX_W-1:0]    rd_idx,
  output sot_pkg::seg_entry_t rd_data
);
  import sot_pkg::*;

  seg_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
  end

endmodule

// ----- rtl/segment_offset_translator.sv -----
// Top level of the segment offset translator: request sequencer and response register.
// Each request beat gives exactly one response beat. Clear, append and the unused
// opcode go from idle straight to the response state. A patch walks the table
// segment by segment through the fetch and test states, since the single table read
// port and the one shared subtractor handle one entry at a time; a hit then passes
// the address state, while a miss or an empty table goes to the response state. The
// request side is ready only between requests; a finished response waits in the
// output register while the next request is accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module segment_offset_translator #(
  parameter int MAX_SEGMENTS = sot_pkg::SOT_MAX_SEGMENTS
) (
  input logic       clk,
  input logic       rst,
  sot_req_if.sink   req,
  sot_rsp_if.source rsp
);
  import sot_pkg::*;

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_TEST  = 5'b00100,
    S_ADDR  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [31:0]       rem;
  logic [1:0]        pend_status;
  logic [31:0]       pend_addr;
  logic [7:0]        pend_byte;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [31:0]       out_addr;
  logic [7:0]        out_byte;

  logic              accept;
  logic              full;
  logic              last;
  logic              slot_free;
  logic              wr_en;
  seg_entry_t        wr_data;
  seg_entry_t        rd_data;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(MAX_SEGMENTS));
  assign last      = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign slot_free = !out_valid || rsp.ready;
  assign wr_en     = accept && (req.opcode == OP_APPEND) && !full;
  assign wr_data   = '{base: req.seg_base_in, length: req.seg_length_in};

  sot_table #(
    .DEPTH (MAX_SEGMENTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_idx  (idx),
    .rd_data (rd_data)
  );

  always_comb begin
    if (state == S_ADDR) begin
      alu_req = '{op: ALU_ADD, a: rd_data.base, b: rem};
    end else begin
      alu_req = '{op: ALU_SUB, a: rem, b: rd_data.length};
    end
  end

  sot_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.opcode == OP_PATCH && count != '0) begin
            state_next = S_FETCH;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_FETCH: state_next = S_TEST;
      S_TEST: begin
        if (alu_rsp.borrow) begin
          state_next = S_ADDR;
        end else if (last) begin
          state_next = S_RESP;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_ADDR: state_next = S_RESP;
      S_RESP: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && req.opcode == OP_CLEAR) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + CNT_W'(1);
      end
      if (state == S_RESP && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        rem       <= req.flat_offset;
        pend_byte <= req.patch_byte;
        idx       <= '0;
        case (req.opcode)
          OP_APPEND: pend_status <= full ? ST_FULL : ST_ACCEPTED;
          OP_PATCH:  pend_status <= ST_OUTSIDE;
          default:   pend_status <= ST_ACCEPTED;
        endcase
      end
      S_TEST: begin
        if (!alu_rsp.borrow) begin
          rem <= alu_rsp.result;
          if (!last) begin
            idx <= idx + IDX_W'(1);
          end
        end
      end
      S_ADDR: begin
        pend_addr   <= alu_rsp.result;
        pend_status <= ST_WRITE;
      end
      S_RESP: begin
        if (slot_free) begin
          out_status <= pend_status;
          out_addr   <= (pend_status == ST_WRITE) ? pend_addr : '0;
          out_byte   <= (pend_status == ST_WRITE) ? pend_byte : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.write_address = out_addr;
  assign rsp.write_byte    = out_byte;

  `SOT_ASSERT_NEVER(a_count_bound, clk, rst, count > CNT_W'(MAX_SEGMENTS))
  `SOT_ASSERT(a_busy_after_accept, clk, rst, accept |=> !req.ready)
  `SOT_ASSERT(a_walk_in_table, clk, rst, (state == S_TEST) |-> (CNT_W'(idx) < count))
  `SOT_ASSERT(a_resp_loads_slot, clk, rst, (state == S_RESP && slot_free) |=> out_valid)

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the segment offset translator.
`timescale 1ns / 1ps
module tb;
  import sot_pkg::*;

  localparam int SEGMENTS = SOT_MAX_SEGMENTS;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 1900;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 500;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] base;
    logic [31:0] length;
    logic [31:0] offset;
    logic [7:0]  data;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
    logic [7:0]  data;
  } response_t;

  typedef struct packed {
    request_t   req;
    logic [7:0] reps;
    bit         typed;
    response_t  rsp;
  } plan_row_t;

  logic clk;
  logic rst;

  sot_req_if req_ch ();
  sot_rsp_if rsp_ch ();

  segment_offset_translator #(
    .MAX_SEGMENTS(SEGMENTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic [31:0] seg_base [SEGMENTS];
  logic [31:0] seg_len [SEGMENTS];
  int          seg_count;

  response_t   awaited[$];
  plan_row_t   plan[$];
  response_t   head;
  int          mismatches;
  int          beats_sent;
  int          burst_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic request_t make_req(logic [1:0] op, logic [31:0] base,
                                        logic [31:0] length, logic [31:0] offset,
                                        logic [7:0] data);
    request_t r;
    r.op = op;
    r.base = base;
    r.length = length;
    r.offset = offset;
    r.data = data;
    return r;
  endfunction

  // Applies one request to the shadow table and returns the response it must give.
  function automatic response_t translate_request(request_t r);
    response_t res;
    logic [31:0] rem;
    bit found;
    res = '0;
    res.status = ST_ACCEPTED;
    case (r.op)
      OP_CLEAR: begin
        seg_count = 0;
      end
      OP_APPEND: begin
        if (seg_count >= SEGMENTS) begin
          res.status = ST_FULL;
        end else begin
          seg_base[seg_count] = r.base;
          seg_len[seg_count] = r.length;
          seg_count++;
        end
      end
      OP_PATCH: begin
        rem = r.offset;
        found = 1'b0;
        res.status = ST_OUTSIDE;
        for (int i = 0; i < seg_count && !found; i++) begin
          if (rem < seg_len[i]) begin
            found = 1'b1;
            res.status = ST_WRITE;
            res.addr = seg_base[i] + rem;
            res.data = r.data;
          end else begin
            rem = rem - seg_len[i];
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1, 2, 3, 4: return $urandom_range(1, 64);
      5, 6, 7: return $urandom_range(1, 65535);
      default: return $urandom;
    endcase
  endfunction

  // Mostly lands inside a stored segment, sometimes on or just before the end.
  function automatic logic [31:0] pick_offset();
    logic [63:0] total;
    logic [63:0] start;
    int k;
    total = 0;
    start = 0;
    for (int i = 0; i < seg_count; i++) total += seg_len[i];
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return total[31:0];
      2: return total[31:0] - 32'd1;
      default: begin
        if (seg_count == 0) return $urandom_range(0, 15);
        k = $urandom_range(0, seg_count - 1);
        for (int i = 0; i < k; i++) start += seg_len[i];
        if (seg_len[k] == 0) return start[31:0];
        return start[31:0] + ($urandom % seg_len[k]);
      end
    endcase
  endfunction

  task automatic plan_row(logic [1:0] op, logic [31:0] base, logic [31:0] length,
                          logic [31:0] offset, logic [7:0] data, int reps, bit typed,
                          logic [1:0] st, logic [31:0] addr, logic [7:0] wbyte);
    plan_row_t row;
    row.req = make_req(op, base, length, offset, data);
    row.reps = 8'(reps);
    row.typed = typed;
    row.rsp.status = st;
    row.rsp.addr = addr;
    row.rsp.data = wbyte;
    plan.push_back(row);
  endtask

  task automatic offer(request_t r, bit typed, response_t typed_rsp);
    response_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.opcode <= r.op;
    req_ch.seg_base_in <= r.base;
    req_ch.seg_length_in <= r.length;
    req_ch.flat_offset <= r.offset;
    req_ch.patch_byte <= r.data;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predicted = translate_request(r);
    if (typed) predicted = typed_rsp;
    awaited.push_back(predicted);
    beats_sent++;
  endtask

  initial begin : stimulus
    int random_start;
    int n;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_CLEAR;
    req_ch.seg_base_in <= '0;
    req_ch.seg_length_in <= '0;
    req_ch.flat_offset <= '0;
    req_ch.patch_byte <= '0;
    mismatches = 0;
    beats_sent = 0;
    burst_left = 0;
    seg_count = 0;

    plan_row(OP_PATCH, 0, 0, 0, 8'h5A, 1, 1, ST_OUTSIDE, 0, 0);
    plan_row(OP_UNUSED, '1, '1, '1, '1, 1, 1, ST_ACCEPTED, 0, 0);
    plan_row(OP_APPEND, 32'hFFFF_FFF0, 0, 0, 0, 1, 1, ST_ACCEPTED, 0, 0);
    plan_row(OP_APPEND, 32'hFFFF_FFF0, 32'h20, 0, 0, 1, 1, ST_ACCEPTED, 0, 0);
    plan_row(OP_PATCH, 0, 0, 0, 8'hFF, 1, 1, ST_WRITE, 32'hFFFF_FFF0, 8'hFF);
    plan_row(OP_PATCH, 0, 0, 32'h1F, 8'h00, 1, 1, ST_WRITE, 32'h0000_000F, 8'h00);
    plan_row(OP_PATCH, 0, 0, 32'h20, 8'h11, 1, 1, ST_OUTSIDE, 0, 0);
    plan_row(OP_PATCH, 0, 0, '1, 8'h11, 1, 1, ST_OUTSIDE, 0, 0);
    plan_row(OP_APPEND, 32'h0000_1000, '1, 0, 0, 1, 1, ST_ACCEPTED, 0, 0);
    plan_row(OP_PATCH, 0, 0, '1, 8'h3C, 1, 0, ST_ACCEPTED, 0, 0);
    plan_row(OP_PATCH, 0, 0, 32'h20, 8'hC3, 1, 0, ST_ACCEPTED, 0, 0);
    plan_row(OP_CLEAR, '1, '1, '1, '1, 1, 1, ST_ACCEPTED, 0, 0);
    plan_row(OP_PATCH, 0, 0, 0, 8'h77, 1, 1, ST_OUTSIDE, 0, 0);
    plan_row(OP_APPEND, 32'h8000_0000, 32'h10, 0, 0, SEGMENTS, 1, ST_ACCEPTED, 0, 0);
    plan_row(OP_APPEND, 32'h1234_5678, 32'h10, 0, 0, 1, 1, ST_FULL, 0, 0);
    plan_row(OP_PATCH, 0, 0, SEGMENTS * 16 - 1, 8'hA5, 1, 1, ST_WRITE,
             32'h8000_000F, 8'hA5);
    plan_row(OP_PATCH, 0, 0, SEGMENTS * 16, 8'hA5, 1, 1, ST_OUTSIDE, 0, 0);
    plan_row(OP_PATCH, 0, 0, 0, 8'h5A, 1, 1, ST_WRITE, 32'h8000_0000, 8'h5A);
    plan_row(OP_PATCH, 0, 0, 32'h155, 8'h96, 1, 0, ST_ACCEPTED, 0, 0);
    plan_row(OP_CLEAR, 0, 0, 0, 0, 1, 1, ST_ACCEPTED, 0, 0);
    plan_row(OP_APPEND, 0, 0, 0, 0, 1, 1, ST_ACCEPTED, 0, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      repeat (plan[i].reps) offer(plan[i].req, plan[i].typed, plan[i].rsp);
    end

    random_start = beats_sent;
    while (beats_sent < random_start + RANDOM_BEATS) begin
      if ($urandom_range(0, 9) < 7) begin
        offer(make_req(OP_CLEAR, $urandom, $urandom, $urandom, 8'($urandom_range(0, 255))),
              0, '0);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, SEGMENTS + 6)
                                        : $urandom_range(1, 8);
        repeat (n) begin
          offer(make_req(OP_APPEND, $urandom, pick_length(), $urandom,
                         8'($urandom_range(0, 255))), 0, '0);
        end
        repeat ($urandom_range(2, 10)) begin
          offer(make_req(OP_PATCH, $urandom, $urandom, pick_offset(),
                         8'($urandom_range(0, 255))), 0, '0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          offer(make_req(2'($urandom_range(0, 3)), $urandom, pick_length(), pick_offset(),
                         8'($urandom_range(0, 255))), 0, '0);
        end
      end
    end
    req_ch.valid <= 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    repeat (2 * SEGMENTS + 8) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // The receiver switches at random between pacing modes and holds off once for a long stretch.
  initial begin : response_pacing
    int mode;
    int phase_len;
    int cycles;
    bit held;
    rsp_ch.ready <= 1'b0;
    cycles = 0;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      phase_len = $urandom_range(10, 150);
      repeat (phase_len) begin
        @(posedge clk);
        cycles++;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      if (!held && cycles >= 3000) begin
        @(posedge clk);
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        cycles += LONG_HOLD + 1;
        held = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (awaited.size() == 0) begin
        $error("response beat with no request outstanding");
        mismatches++;
      end else begin
        head = awaited.pop_front();
        if (rsp_ch.status !== head.status) begin
          $error("field status expected %0d actual %0d", head.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.write_address !== head.addr) begin
          $error("field write_address expected %h actual %h", head.addr,
                 rsp_ch.write_address);
          mismatches++;
        end
        if (rsp_ch.write_byte !== head.data) begin
          $error("field write_byte expected %h actual %h", head.data, rsp_ch.write_byte);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

endmodule
